/* rtl/tvnca_pkg.sv */
// ----------------------------------------------------------------------------
// tvnca_pkg
// Shared types and constants of the toroidal von Neumann lookup-table
// cellular automaton engine.
// ----------------------------------------------------------------------------
package tvnca_pkg;

  // Default grid side held in the cell store
  localparam int GRID_SIDE_MAX_DEF = 64;

  // Field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 6;
  localparam int CELL_W   = 4;
  localparam int RULE_AW  = 20;
  localparam int SIDE_W   = 7;
  localparam int COORD_W  = 7;
  localparam int SIDE_CMP_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam int RULE_DEPTH = 1 << RULE_AW;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RULE_WR = 2'd0;
  localparam logic [OP_W-1:0] OP_CELL_WR = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  // Input transaction
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   cell_x;
    logic [POS_W-1:0]   cell_y;
    logic [RULE_AW-1:0] rule_address;
    logic [CELL_W-1:0]  value;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [CELL_W-1:0]  next_state;
    logic [RULE_AW-1:0] neighbourhood_address;
    logic               bad_coordinate;
  } out_t;

  // Decoded item after the front stage
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               bad;
    logic               cell_we;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] wx;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ny;
    logic [COORD_W-1:0] sy;
    logic [RULE_AW-1:0] rule_address;
    logic [CELL_W-1:0]  value;
  } stage1_t;

endpackage

/* rtl/tvnca_grid_bank.sv */
// ----------------------------------------------------------------------------
// tvnca_grid_bank
// One copy of the cell store: single write port and RD_PORTS registered
// read ports.
// ----------------------------------------------------------------------------
module tvnca_grid_bank #(
  parameter int DEPTH    = 4096,
  parameter int AW       = 12,
  parameter int RD_PORTS = 2
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tvnca_pkg::CELL_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr [RD_PORTS],
  output logic [tvnca_pkg::CELL_W-1:0] rdata [RD_PORTS]
);

  logic [tvnca_pkg::CELL_W-1:0] mem [DEPTH];

  // Write the cell
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read all ports, hold data while the pipe stalls
  always_ff @(posedge clk) begin
    for (int i = 0; i < RD_PORTS; i++) begin
      if (re) begin
        rdata[i] <= mem[raddr[i]];
      end
    end
  end

endmodule

/* rtl/tvnca_rule_mem.sv */
// ----------------------------------------------------------------------------
// tvnca_rule_mem
// Rule table: 2^20 entries of 4 bits, one write and one registered read.
// ----------------------------------------------------------------------------
module tvnca_rule_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [tvnca_pkg::RULE_AW-1:0] waddr,
  input  logic [tvnca_pkg::CELL_W-1:0]  wdata,
  input  logic                          re,
  input  logic [tvnca_pkg::RULE_AW-1:0] raddr,
  output logic [tvnca_pkg::CELL_W-1:0]  rdata
);

  logic [tvnca_pkg::CELL_W-1:0] mem [tvnca_pkg::RULE_DEPTH];

  // Write the entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the entry, hold it while the output stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tvnca_front.sv */
// ----------------------------------------------------------------------------
// tvnca_front
// Configuration registers and the front stage: clamp the grid size, check
// the coordinates and work out the toroidal neighbor coordinates.
// ----------------------------------------------------------------------------
module tvnca_front #(
  parameter int GRID_SIDE_MAX = tvnca_pkg::GRID_SIDE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tvnca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvnca_pkg::SIDE_W-1:0]    cfg_data,
  input  logic                            in_valid,
  input  tvnca_pkg::in_t                  in_payload,
  input  logic                            advance,
  output logic                            s1_valid,
  output tvnca_pkg::stage1_t              s1
);

  localparam logic [tvnca_pkg::SIDE_CMP_W-1:0] SIDE_MAX =
    tvnca_pkg::SIDE_CMP_W'(GRID_SIDE_MAX);

  logic [tvnca_pkg::SIDE_W-1:0]  width_r, height_r;
  logic [tvnca_pkg::SIDE_W-1:0]  w_eff, h_eff;
  logic [tvnca_pkg::COORD_W-1:0] x7, y7;
  logic                          bad, is_eval, cell_we, in_store;
  tvnca_pkg::stage1_t            s1_nxt;
  tvnca_pkg::stage1_t            s1_r;
  logic                          s1_valid_r;

  // Clamp a size register into 1 .. GRID_SIDE_MAX
  function automatic logic [tvnca_pkg::SIDE_W-1:0] eff_side(
    input logic [tvnca_pkg::SIDE_W-1:0] v
  );
    logic [tvnca_pkg::SIDE_CMP_W-1:0] wide;
    wide = tvnca_pkg::SIDE_CMP_W'(v);
    if (v == '0) begin
      return tvnca_pkg::SIDE_W'(1);
    end else if (wide > SIDE_MAX) begin
      return tvnca_pkg::SIDE_W'(GRID_SIDE_MAX);
    end
    return v;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= tvnca_pkg::SIDE_RESET;
      height_r <= tvnca_pkg::SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvnca_pkg::CFG_GRID_WIDTH:  width_r  <= cfg_data;
        tvnca_pkg::CFG_GRID_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode and wrap
  always_comb begin
    w_eff    = eff_side(width_r);
    h_eff    = eff_side(height_r);
    x7       = tvnca_pkg::COORD_W'(in_payload.cell_x);
    y7       = tvnca_pkg::COORD_W'(in_payload.cell_y);
    bad      = (x7 >= w_eff) || (y7 >= h_eff);
    is_eval  = (in_payload.op == tvnca_pkg::OP_EVAL) && !bad;
    in_store = (tvnca_pkg::SIDE_CMP_W'(x7) < SIDE_MAX) &&
               (tvnca_pkg::SIDE_CMP_W'(y7) < SIDE_MAX);
    cell_we  = (in_payload.op == tvnca_pkg::OP_CELL_WR) && in_store;

    s1_nxt              = '0;
    s1_nxt.op           = in_payload.op;
    s1_nxt.bad          = bad;
    s1_nxt.cell_we      = cell_we;
    s1_nxt.rule_address = in_payload.rule_address;
    s1_nxt.value        = in_payload.value;
    // keep every address inside the store
    if (is_eval || cell_we) begin
      s1_nxt.x = x7;
      s1_nxt.y = y7;
    end
    if (is_eval) begin
      s1_nxt.wx = (x7 == '0) ? w_eff - 7'd1 : x7 - 7'd1;
      s1_nxt.ex = (x7 + 7'd1 < w_eff) ? x7 + 7'd1 : '0;
      s1_nxt.ny = (y7 == '0) ? h_eff - 7'd1 : y7 - 7'd1;
      s1_nxt.sy = (y7 + 7'd1 < h_eff) ? y7 + 7'd1 : '0;
    end
  end

  // Stage register: advance when the next stage can take it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

/* rtl/toroidal_von_neumann_ca_lookup_top.sv */
// ----------------------------------------------------------------------------
// toroidal_von_neumann_ca_lookup_top
// Lookup-table cellular automaton engine on a toroidal grid with a von
// Neumann neighborhood: rule writes, cell writes and per-cell evaluation.
//
//   Channel  Ports                                 Moves
//   input    in_valid / in_ready / in_payload      op, cell, rule write data
//   result   out_valid / out_ready / out_payload   next state of one cell
//   config   cfg_we / cfg_index / cfg_data         grid width, grid height
//
// One transaction per cycle is accepted while in_ready is high; an evaluation
// passes the front stage register and the stage 2 cell reads before the
// stage 3 output register raises out_valid with the rule read. The rate is
// set by the cell store, held in three copies with two, two and one read ports
// to fetch five cells a cycle, and by the one read port of the rule table.
// Reset clears only control state; both stores hold unknown data until
// written, with no clearing pass. A stalled result stops only the stages
// behind it that are occupied.
// ----------------------------------------------------------------------------
module toroidal_von_neumann_ca_lookup_top #(
  parameter int GRID_SIDE_MAX = tvnca_pkg::GRID_SIDE_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tvnca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvnca_pkg::SIDE_W-1:0]    cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tvnca_pkg::in_t                  in_payload,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tvnca_pkg::out_t                 out_payload
);

  localparam int GRID_DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int AW         = $clog2(GRID_DEPTH);
  localparam int CW         = tvnca_pkg::CELL_W;

  logic               adv1, adv2, adv3;
  logic               s1_valid;
  tvnca_pkg::stage1_t s1;

  logic [AW-1:0] a_c, a_n, a_s, a_e, a_w;
  logic [AW-1:0] rd0_addr [2];
  logic [AW-1:0] rd1_addr [2];
  logic [AW-1:0] rd2_addr [1];
  logic [CW-1:0] rd0_data [2];
  logic [CW-1:0] rd1_data [2];
  logic [CW-1:0] rd2_data [1];
  logic          grid_we;

  logic                          v2_r;
  logic [tvnca_pkg::OP_W-1:0]    op2_r;
  logic                          bad2_r;
  logic [tvnca_pkg::RULE_AW-1:0] rule_addr2_r;
  logic [CW-1:0]                 value2_r;
  logic [tvnca_pkg::RULE_AW-1:0] packed2;
  logic                          rule_we;
  logic [CW-1:0]                 rule_q;

  logic                          v3_r;
  logic                          bad3_r;
  logic [tvnca_pkg::RULE_AW-1:0] packed3_r;

  // Linear cell address: row-major with GRID_SIDE_MAX columns
  function automatic logic [AW-1:0] cell_addr(
    input logic [tvnca_pkg::COORD_W-1:0] cx,
    input logic [tvnca_pkg::COORD_W-1:0] cy
  );
    int t;
    t = int'(cy) * GRID_SIDE_MAX + int'(cx);
    return AW'(t);
  endfunction

  // Pipeline advance: a stage moves when it is empty or its successor moves
  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  tvnca_front #(
    .GRID_SIDE_MAX(GRID_SIDE_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_payload(in_payload),
    .advance   (adv1),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  // Cell addresses of the neighborhood
  always_comb begin
    a_c = cell_addr(s1.x,  s1.y);
    a_n = cell_addr(s1.x,  s1.ny);
    a_s = cell_addr(s1.x,  s1.sy);
    a_e = cell_addr(s1.ex, s1.y);
    a_w = cell_addr(s1.wx, s1.y);
    rd0_addr[0] = a_c;
    rd0_addr[1] = a_n;
    rd1_addr[0] = a_s;
    rd1_addr[1] = a_e;
    rd2_addr[0] = a_w;
  end

  // Cell writes land in every copy, in the same stage as the reads
  assign grid_we = adv2 && s1_valid && s1.cell_we;

  tvnca_grid_bank #(.DEPTH(GRID_DEPTH), .AW(AW), .RD_PORTS(2)) u_bank0 (
    .clk(clk), .we(grid_we), .waddr(a_c), .wdata(s1.value),
    .re(adv2), .raddr(rd0_addr), .rdata(rd0_data)
  );

  tvnca_grid_bank #(.DEPTH(GRID_DEPTH), .AW(AW), .RD_PORTS(2)) u_bank1 (
    .clk(clk), .we(grid_we), .waddr(a_c), .wdata(s1.value),
    .re(adv2), .raddr(rd1_addr), .rdata(rd1_data)
  );

  tvnca_grid_bank #(.DEPTH(GRID_DEPTH), .AW(AW), .RD_PORTS(1)) u_bank2 (
    .clk(clk), .we(grid_we), .waddr(a_c), .wdata(s1.value),
    .re(adv2), .raddr(rd2_addr), .rdata(rd2_data)
  );

  // Stage 2 control, alongside the cell read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      op2_r        <= s1.op;
      bad2_r       <= s1.bad;
      rule_addr2_r <= s1.rule_address;
      value2_r     <= s1.value;
    end
  end

  // Pack the neighborhood: west high, center low; zero on a bad coordinate
  assign packed2 = bad2_r ? '0 :
                   {rd2_data[0], rd1_data[1], rd1_data[0], rd0_data[1], rd0_data[0]};

  // Rule writes and reads share stage 2, keeping program order
  assign rule_we = adv3 && v2_r && (op2_r == tvnca_pkg::OP_RULE_WR);

  tvnca_rule_mem u_rule (
    .clk  (clk),
    .we   (rule_we),
    .waddr(rule_addr2_r),
    .wdata(value2_r),
    .re   (adv3),
    .raddr(packed2),
    .rdata(rule_q)
  );

  // Stage 3: output register, only evaluations produce a transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r && (op2_r == tvnca_pkg::OP_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      bad3_r    <= bad2_r;
      packed3_r <= packed2;
    end
  end

  assign out_valid                         = v3_r;
  assign out_payload.next_state            = bad3_r ? '0 : rule_q;
  assign out_payload.neighbourhood_address = packed3_r;
  assign out_payload.bad_coordinate        = bad3_r;

endmodule

/* test/tvnca_checker.sv */
// ----------------------------------------------------------------------------
// tvnca_checker
// Watches the input, result and configuration ports of the cellular automaton
// engine. It keeps its own copy of the cell grid, the rule table and the grid
// size, predicts the next state of every evaluated cell, and compares each
// result against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tvnca_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tvnca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvnca_pkg::SIDE_W-1:0]    cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  tvnca_pkg::in_t                  in_payload,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  tvnca_pkg::out_t                 out_payload,
  output int                              fail_count,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = tvnca_pkg::GRID_SIDE_MAX_DEF;

  // Shadow stores and grid size
  bit [tvnca_pkg::CELL_W-1:0]   rule_mem [tvnca_pkg::RULE_DEPTH];
  bit [tvnca_pkg::CELL_W-1:0]   grid_mem [SIDE*SIDE];
  logic [tvnca_pkg::SIDE_W-1:0] width_raw  = tvnca_pkg::SIDE_RESET;
  logic [tvnca_pkg::SIDE_W-1:0] height_raw = tvnca_pkg::SIDE_RESET;

  // Predicted results, oldest first
  tvnca_pkg::out_t next_states_due [$];
  int              mismatches = 0;

  // Zero acts as one, anything past the store acts as the full side
  function automatic int side_in_use(logic [tvnca_pkg::SIDE_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > SIDE) return SIDE;
    return int'(raw);
  endfunction

  function automatic logic [tvnca_pkg::CELL_W-1:0] cell_at(int x, int y);
    return grid_mem[y*SIDE + x];
  endfunction

  // Gather the five cells with toroidal wrap and look up the rule
  function automatic tvnca_pkg::out_t next_state_of(int x, int y);
    int              w, h, north, south, west, east;
    tvnca_pkg::out_t res;
    w   = side_in_use(width_raw);
    h   = side_in_use(height_raw);
    res = '0;
    if (x >= w || y >= h) begin
      res.bad_coordinate = 1'b1;
      return res;
    end
    north = (y > 0) ? y - 1 : h - 1;
    south = (y + 1 < h) ? y + 1 : 0;
    west  = (x > 0) ? x - 1 : w - 1;
    east  = (x + 1 < w) ? x + 1 : 0;
    res.neighbourhood_address = {cell_at(west, y), cell_at(east, y), cell_at(x, south),
                                 cell_at(x, north), cell_at(x, y)};
    res.next_state = rule_mem[res.neighbourhood_address];
    return res;
  endfunction

  task automatic apply_transaction(tvnca_pkg::in_t t);
    case (t.op)
      tvnca_pkg::OP_RULE_WR: rule_mem[t.rule_address] = t.value;
      // 6-bit coordinates always land inside the store
      tvnca_pkg::OP_CELL_WR: grid_mem[int'(t.cell_y)*SIDE + int'(t.cell_x)] = t.value;
      tvnca_pkg::OP_EVAL:    next_states_due.push_back(next_state_of(t.cell_x, t.cell_y));
      default: ;
    endcase
  endtask

  task automatic compare_result(tvnca_pkg::out_t got);
    tvnca_pkg::out_t want;
    if (next_states_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch: unexpected result next_state %h address %h bad %b",
                 $time, got.next_state, got.neighbourhood_address, got.bad_coordinate);
      return;
    end
    want = next_states_due.pop_front();
    if (got.next_state !== want.next_state ||
        got.neighbourhood_address !== want.neighbourhood_address ||
        got.bad_coordinate !== want.bad_coordinate) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch: expected next_state %h address %h bad %b, got %h %h %b",
                 $time, want.next_state, want.neighbourhood_address, want.bad_coordinate,
                 got.next_state, got.neighbourhood_address, got.bad_coordinate);
    end
  endtask

  // Track configuration, check accepted results, absorb accepted inputs
  always @(posedge clk) begin
    if (!rst_n) begin
      width_raw  = tvnca_pkg::SIDE_RESET;
      height_raw = tvnca_pkg::SIDE_RESET;
      next_states_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tvnca_pkg::CFG_GRID_WIDTH:  width_raw  = cfg_data;
          tvnca_pkg::CFG_GRID_HEIGHT: height_raw = cfg_data;
        endcase
      end
      if (out_valid && out_ready) compare_result(out_payload);
      if (in_valid && in_ready) apply_transaction(in_payload);
    end
    outstanding <= next_states_due.size();
    fail_count  <= mismatches;
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the cellular automaton engine with rule writes, cell writes and
// cell evaluations under several grid sizes and handshake idling patterns.
// Every evaluation only touches cells and rule entries written before it;
// the checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE          = tvnca_pkg::GRID_SIDE_MAX_DEF;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 90;
  localparam int SETTLE_CYCLES = 8;
  localparam int CW            = tvnca_pkg::CELL_W;
  localparam int AWR           = tvnca_pkg::RULE_AW;
  localparam int SW            = tvnca_pkg::SIDE_W;

  // Op code the block ignores
  localparam logic [tvnca_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [tvnca_pkg::CFG_IDX_W-1:0] cfg_index  = tvnca_pkg::CFG_GRID_WIDTH;
  logic [SW-1:0]                   cfg_data   = '0;
  logic                            in_valid   = 1'b0;
  tvnca_pkg::in_t                  in_payload = '0;
  logic                            out_ready  = 1'b0;
  logic                            in_ready;
  logic                            out_valid;
  tvnca_pkg::out_t                 out_payload;
  int                              fail_count;
  int                              outstanding;

  // Idling knobs, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;

  // What has been written so far, so evaluations never read stale entries
  bit [CW-1:0]    cell_shadow [SIDE*SIDE];
  bit             cell_known [SIDE*SIDE];
  bit             rule_known [int];
  logic [AWR-1:0] recent_rules [$];
  int             w_eff = SIDE;
  int             h_eff = SIDE;
  int             sent  = 0;

  always #6 clk = ~clk;

  toroidal_von_neumann_ca_lookup_top #(.GRID_SIDE_MAX(SIDE)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

  tvnca_checker ca_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int side_in_use(logic [SW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > SIDE) return SIDE;
    return int'(raw);
  endfunction

  function automatic tvnca_pkg::in_t random_item();
    tvnca_pkg::in_t t;
    t.op           = tvnca_pkg::OP_W'($urandom);
    t.cell_x       = tvnca_pkg::POS_W'($urandom);
    t.cell_y       = tvnca_pkg::POS_W'($urandom);
    t.rule_address = AWR'($urandom);
    t.value        = CW'($urandom);
    return t;
  endfunction

  // Present one transaction after a random gap, hold until accepted
  task automatic issue_item(input tvnca_pkg::in_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    case (t.op)
      tvnca_pkg::OP_CELL_WR: begin
        cell_shadow[int'(t.cell_y)*SIDE + int'(t.cell_x)] = t.value;
        cell_known[int'(t.cell_y)*SIDE + int'(t.cell_x)]  = 1'b1;
      end
      tvnca_pkg::OP_RULE_WR: begin
        rule_known[int'(t.rule_address)] = 1'b1;
        recent_rules.push_back(t.rule_address);
        if (recent_rules.size() > 32) void'(recent_rules.pop_front());
      end
      default: ;
    endcase
  endtask

  task automatic write_cell(input int x, input int y, input logic [CW-1:0] v);
    tvnca_pkg::in_t t;
    t        = random_item();
    t.op     = tvnca_pkg::OP_CELL_WR;
    t.cell_x = tvnca_pkg::POS_W'(x);
    t.cell_y = tvnca_pkg::POS_W'(y);
    t.value  = v;
    issue_item(t);
  endtask

  task automatic write_rule(input logic [AWR-1:0] a, input logic [CW-1:0] v);
    tvnca_pkg::in_t t;
    t              = random_item();
    t.op           = tvnca_pkg::OP_RULE_WR;
    t.rule_address = a;
    t.value        = v;
    issue_item(t);
  endtask

  task automatic issue_eval(input int x, input int y);
    tvnca_pkg::in_t t;
    t        = random_item();
    t.op     = tvnca_pkg::OP_EVAL;
    t.cell_x = tvnca_pkg::POS_W'(x);
    t.cell_y = tvnca_pkg::POS_W'(y);
    issue_item(t);
  endtask

  // Fill any unwritten neighbor and rule entry first, then evaluate
  task automatic evaluate_at(input int x, input int y);
    int             xs [5];
    int             ys [5];
    logic [AWR-1:0] a;
    xs[0] = x;
    ys[0] = y;
    xs[1] = x;
    ys[1] = (y > 0) ? y - 1 : h_eff - 1;
    xs[2] = x;
    ys[2] = (y + 1 < h_eff) ? y + 1 : 0;
    xs[3] = (x + 1 < w_eff) ? x + 1 : 0;
    ys[3] = y;
    xs[4] = (x > 0) ? x - 1 : w_eff - 1;
    ys[4] = y;
    for (int i = 0; i < 5; i++) begin
      if (!cell_known[ys[i]*SIDE + xs[i]]) write_cell(xs[i], ys[i], CW'($urandom));
    end
    a = '0;
    for (int i = 4; i >= 0; i--) a = (a << CW) | cell_shadow[ys[i]*SIDE + xs[i]];
    if (!rule_known.exists(int'(a)) || $urandom_range(3) == 0)
      write_rule(a, CW'($urandom));
    issue_eval(x, y);
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input logic [SW-1:0] w_raw, input logic [SW-1:0] h_raw);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= tvnca_pkg::CFG_GRID_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    cfg_index <= tvnca_pkg::CFG_GRID_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    w_eff = side_in_use(w_raw);
    h_eff = side_in_use(h_raw);
  endtask

  task automatic random_transaction();
    int             pick, x, y;
    tvnca_pkg::in_t t;
    pick = $urandom_range(99);
    if (pick < 45 || (pick >= 80 && pick < 93 && w_eff == SIDE && h_eff == SIDE)) begin
      evaluate_at($urandom_range(w_eff - 1), $urandom_range(h_eff - 1));
    end else if (pick < 65) begin
      // cell writes ignore the grid size, so cover the whole store too
      if ($urandom_range(1))
        write_cell($urandom_range(w_eff - 1), $urandom_range(h_eff - 1), CW'($urandom));
      else
        write_cell($urandom_range(SIDE - 1), $urandom_range(SIDE - 1), CW'($urandom));
    end else if (pick < 80) begin
      if (recent_rules.size() != 0 && $urandom_range(1))
        write_rule(recent_rules[$urandom_range(recent_rules.size() - 1)], CW'($urandom));
      else
        write_rule(AWR'($urandom), CW'($urandom));
    end else if (pick < 93) begin
      // coordinate outside the configured grid
      x = $urandom_range(SIDE - 1);
      y = $urandom_range(SIDE - 1);
      if (w_eff < SIDE && (h_eff == SIDE || $urandom_range(1)))
        x = $urandom_range(SIDE - 1, w_eff);
      else
        y = $urandom_range(SIDE - 1, h_eff);
      issue_eval(x, y);
    end else begin
      t    = random_item();
      t.op = OP_UNUSED;
      issue_item(t);
    end
  endtask

  // Overall time limit
  initial begin
    #5ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int             phase_end;
    tvnca_pkg::in_t probe;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the rule address, corner cells and wrap at full size
    write_rule('0, 4'hF);
    write_rule('1, 4'h0);
    write_cell(0, 0, 4'h0);
    write_cell(SIDE - 1, SIDE - 1, 4'hF);
    write_cell(SIDE - 1, 0, 4'hF);
    write_cell(0, SIDE - 1, 4'hF);
    write_cell(1, 0, 4'hA);
    write_cell(0, 1, 4'h5);
    evaluate_at(0, 0);
    evaluate_at(SIDE - 1, SIDE - 1);
    // Unused op with every field bit set
    probe = '1;
    issue_item(probe);
    // Zero size acts as one: all five reads hit the same cell
    set_grid('0, '0);
    evaluate_at(0, 0);
    issue_eval(SIDE - 1, SIDE - 1);
    issue_eval(1, 0);
    issue_eval(0, 1);
    // Oversize acts as full size
    set_grid('1, '1);
    evaluate_at(SIDE - 1, 0);
    evaluate_at(SIDE / 2, SIDE / 2);

    // Random phases over grid sizes and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_grid(7'd1, 7'd1);
        1:       set_grid(7'd64, 7'd64);
        2:       set_grid(7'd1, 7'd64);
        3:       set_grid(7'd64, 7'd1);
        4:       set_grid(7'd2, 7'd3);
        5:       set_grid(7'd65, 7'd7);
        6:       set_grid(7'd0, 7'd2);
        7:       set_grid(7'd9, 7'd127);
        8:       set_grid(7'd31, 7'd40);
        9:       set_grid(7'd5, 7'd5);
        10:      set_grid(7'd63, 7'd64);
        11:      set_grid(7'd64, 7'd63);
        default: set_grid(SW'($urandom_range(1, 16)), SW'($urandom_range(1, 16)));
      endcase
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 79;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 79;
        end
        default: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
      endcase
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) random_transaction();
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
